### hdl/rld_pkg.sv
// Shared types and constants for the six-bit run-length plane decoder.
package rld_pkg;

  // Register reset values and fixed limits.
  localparam logic [15:0] LINE_BITS_RESET  = 16'd1728;
  localparam logic [15:0] LINE_LIMIT_RESET = 16'd0;
  localparam logic [16:0] LINE_CAP         = 17'd7200;
  localparam logic [16:0] LINES_MAX        = 17'h1FFFF;
  localparam logic [25:0] LEN_MAX          = 26'h3FFFFFF;
  localparam logic [2:0]  NIB_POS_MAX      = 3'd7;
  localparam int          RUN_BITS_DEFAULT = 24;
  localparam int          RES_DEPTH        = 4;

  // Configuration register indexes.
  localparam logic REG_LINE_BITS  = 1'b0;
  localparam logic REG_LINE_LIMIT = 1'b1;

  // Control-code nibbles.
  localparam logic [3:0] NIB_EOL = 4'h0;
  localparam logic [3:0] NIB_EOM = 4'h3;

  typedef enum logic [1:0] {
    FLAG_ZEROS = 2'd0,
    FLAG_ONES  = 2'd1,
    FLAG_LIT   = 2'd2,
    FLAG_CTRL  = 2'd3
  } flag_t;

  typedef enum logic [1:0] {
    FILL_NONE  = 2'd0,
    FILL_ZEROS = 2'd1,
    FILL_ONES  = 2'd2,
    FILL_LIT   = 2'd3
  } fill_t;

  typedef enum logic [1:0] {
    RUN_ZEROS = 2'd0,
    RUN_ONES  = 2'd1,
    RUN_NONE  = 2'd2
  } run_t;

  // One fill command as it leaves the block.
  typedef struct packed {
    fill_t       kind;
    logic [31:0] start;
    logic [25:0] len;
    logic [16:0] lines;
    logic [31:0] total;
    logic        done;
    logic        last;
  } rld_result_t;

  // Results of one decoded code, handed to the result queue.
  typedef struct packed {
    logic        valid;
    logic        two;
    rld_result_t first;
    rld_result_t second;
  } rld_push_t;

endpackage

### hdl/rld_core.sv
// Input register, decoder state and the single-pass decode of one code word.
module rld_core import rld_pkg::*; #(
  parameter int RUN_BITS = RUN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] line_bits,
  input  logic [15:0] line_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  code,
  input  logic        last_code,
  input  logic        space,
  output rld_push_t   push
);

  localparam int SUM_W = ((RUN_BITS > 32) ? RUN_BITS : 32) + 1;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  function automatic logic [31:0] sat32(input logic [35:0] v);
    return (v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  logic                in_full;
  logic [5:0]          code_q;
  logic                last_q;
  logic                fire;

  run_t                run_kind, run_kind_next;
  logic [RUN_BITS-1:0] run_length, run_length_next;
  logic [2:0]          nib_count, nib_count_next;
  logic [31:0]         line_fill, line_fill_next;
  logic [31:0]         completed_bits, completed_bits_next;
  logic [16:0]         lines_done, lines_done_next;
  logic                ended, ended_next;

  flag_t               flag;
  logic [3:0]          nib;
  logic                run_open;
  run_t                kind_new;
  logic [33:0]         len_bits;
  logic [33:0]         len_open;
  logic [25:0]         len_sat;
  logic [31:0]         start_now, start_after, fill_after, fill_lit, cb_eol;
  logic [SUM_W-1:0]    run_sum;
  logic [RUN_BITS-1:0] run_sum_sat;
  logic [RUN_BITS-1:0] line_bits_ext;
  logic                long_run;
  logic [16:0]         lines_inc;
  logic                limit_hit;
  rld_result_t         close_res, lit_res, r0, r1;
  logic                two;

  // The input register frees up whenever its word is decoded.
  assign fire     = in_full && space;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_ready && in_valid) begin
      code_q <= code;
      last_q <= last_code;
    end
  end

  // Arithmetic shared by the code branches.
  assign flag          = flag_t'(code_q[5:4]);
  assign nib           = code_q[3:0];
  assign run_open      = (run_kind == RUN_ZEROS) || (run_kind == RUN_ONES);
  assign kind_new      = (flag == FLAG_ZEROS) ? RUN_ZEROS : RUN_ONES;
  assign len_bits      = 34'(run_length) << 2;
  assign len_open      = run_open ? len_bits : 34'd0;
  assign len_sat       = (len_bits > 34'(LEN_MAX)) ? LEN_MAX : len_bits[25:0];
  assign start_now     = sat32(36'(completed_bits) + 36'(line_fill));
  assign start_after   = sat32(36'(completed_bits) + 36'(line_fill) + 36'(len_open));
  assign fill_after    = sat32(36'(line_fill) + 36'(len_open));
  assign fill_lit      = sat32(36'(line_fill) + 36'(len_open) + 36'd4);
  assign cb_eol        = sat32(36'(completed_bits) + 36'(line_bits));
  assign run_sum       = SUM_W'(run_length) + (SUM_W'(nib) << {nib_count, 2'b00});
  assign run_sum_sat   = (run_sum > SUM_W'(RUN_MAX)) ? RUN_MAX : run_sum[RUN_BITS-1:0];
  assign line_bits_ext = RUN_BITS'(line_bits);
  assign long_run      = run_length > line_bits_ext;
  assign lines_inc     = (lines_done == LINES_MAX) ? lines_done : lines_done + 17'd1;
  assign limit_hit     = (line_limit == 16'd0) ? (lines_inc >= LINE_CAP)
                                               : (lines_inc > 17'(line_limit));

  // Next state and the fill commands of the current word: none, one or two.
  always_comb begin
    run_kind_next       = run_kind;
    run_length_next     = run_length;
    nib_count_next      = nib_count;
    line_fill_next      = line_fill;
    completed_bits_next = completed_bits;
    lines_done_next     = lines_done;
    ended_next          = ended;
    two                 = 1'b0;

    close_res       = '0;
    close_res.kind  = (run_kind == RUN_ZEROS) ? FILL_ZEROS : FILL_ONES;
    close_res.start = start_now;
    close_res.len   = len_sat;
    lit_res         = '0;
    lit_res.kind    = FILL_LIT;
    lit_res.start   = start_after;
    lit_res.len     = 26'(nib);
    r0              = '0;
    r1              = '0;

    if (!ended) begin
      case (flag)
        FLAG_ZEROS, FLAG_ONES: begin
          if (run_kind == kind_new) begin
            run_length_next = run_sum_sat;
            nib_count_next  = (nib_count == NIB_POS_MAX) ? nib_count : nib_count + 3'd1;
            ended_next      = run_sum_sat > line_bits_ext;
          end else begin
            if (run_open) begin
              r0             = close_res;
              line_fill_next = fill_after;
            end
            run_length_next = RUN_BITS'(nib);
            nib_count_next  = 3'd1;
            ended_next      = RUN_BITS'(nib) > line_bits_ext;
          end
          run_kind_next = kind_new;
        end
        FLAG_LIT: begin
          if (run_open) begin
            r0  = close_res;
            r1  = lit_res;
            two = 1'b1;
          end else begin
            r0 = lit_res;
          end
          line_fill_next  = fill_lit;
          ended_next      = long_run;
          run_length_next = '0;
          run_kind_next   = RUN_NONE;
        end
        FLAG_CTRL: begin
          case (nib)
            NIB_EOL: begin
              if (run_open) begin
                r0 = close_res;
              end
              completed_bits_next = cb_eol;
              ended_next          = long_run || limit_hit;
              run_length_next     = '0;
              line_fill_next      = '0;
              lines_done_next     = lines_inc;
            end
            NIB_EOM: begin
              ended_next = 1'b1;
            end
            default: begin
              // Other control codes drop the open run unwritten.
            end
          endcase
          run_kind_next = RUN_NONE;
        end
        default: begin
        end
      endcase
    end

    // Every result carries the line totals as they stand after this word.
    r0.lines = lines_done_next;
    r0.total = completed_bits_next;
    r0.done  = ended_next;
    r0.last  = !two;
    r1.lines = lines_done_next;
    r1.total = completed_bits_next;
    r1.done  = ended_next;
    r1.last  = 1'b1;
  end

  assign push.valid  = fire;
  assign push.two    = two;
  assign push.first  = r0;
  assign push.second = r1;

  // Decoder state; the final word of a region returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (fire && last_q)) begin
      run_kind       <= RUN_NONE;
      run_length     <= '0;
      nib_count      <= '0;
      line_fill      <= '0;
      completed_bits <= '0;
      lines_done     <= '0;
      ended          <= 1'b0;
    end else if (fire) begin
      run_kind       <= run_kind_next;
      run_length     <= run_length_next;
      nib_count      <= nib_count_next;
      line_fill      <= line_fill_next;
      completed_bits <= completed_bits_next;
      lines_done     <= lines_done_next;
      ended          <= ended_next;
    end
  end

endmodule

### hdl/rld_out_fifo.sv
// Result queue; takes one or two fill commands a cycle, pops one on out_ready.
module rld_out_fifo import rld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rld_push_t   push,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output rld_result_t head
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(RES_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  rld_result_t   entries [RES_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;
  logic [CW-1:0] n_push;

  // Room for two words is needed before a code word is decoded.
  assign space     = count <= CW'(RES_DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = push.valid ? (push.two ? CW'(2) : CW'(1)) : '0;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= push.two ? ptr_inc(ptr_inc(wr_ptr)) : ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + n_push - CW'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.first;
      if (push.two) begin
        entries[ptr_inc(wr_ptr)] <= push.second;
      end
    end
  end

endmodule

### hdl/sixbit_run_length_plane_decoder.sv
// Top level of the six-bit run-length plane decoder.
//
//   channel  signals                          direction  moves
//   cfg      cfg_we, cfg_index, cfg_data       in         one register write
//   in       in_valid/in_ready, code, ...      in         one code word
//   out      out_valid/out_ready, fill_kind... out        one fill command word
//
// A code word is taken into the input register and decoded once the queue has
// room for two words; its results then enter the queue, where a literal that
// closes a run takes two words, and are offered from the head of the queue.
// One code word is taken per cycle while the queue has room; the output port
// moves one word per cycle while out_ready is high.
// The four-entry result queue sets how far input runs ahead of a stalled output.
// Reset is synchronous: clears decoder state and queue, presets the registers.
module sixbit_run_length_plane_decoder import rld_pkg::*; #(
  parameter int RUN_BITS = RUN_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  code,
  input  logic        last_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  fill_kind,
  output logic [31:0] start_bit,
  output logic [25:0] length_or_pattern,
  output logic [16:0] line_count,
  output logic [31:0] completed_bits,
  output logic        done_res,
  output logic        last_result
);

  logic [15:0] line_bits;
  logic [15:0] line_limit;
  logic        space;
  rld_push_t   push;
  rld_result_t head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bits  <= LINE_BITS_RESET;
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_BITS:  line_bits  <= cfg_data;
        REG_LINE_LIMIT: line_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rld_core #(
    .RUN_BITS(RUN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .line_bits (line_bits),
    .line_limit(line_limit),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code      (code),
    .last_code (last_code),
    .space     (space),
    .push      (push)
  );

  rld_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  // Output fields from the head of the queue.
  assign fill_kind         = head.kind;
  assign start_bit         = head.start;
  assign length_or_pattern = head.len;
  assign line_count        = head.lines;
  assign completed_bits    = head.total;
  assign done_res          = head.done;
  assign last_result       = head.last;

endmodule

### hdl/rld_checker.sv
// Port-level checks of the plane decoder and their binding to the top level.
module rld_checker import rld_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  fill_kind,
  input logic [31:0] start_bit,
  input logic [25:0] length_or_pattern,
  input logic [16:0] line_count,
  input logic [31:0] completed_bits,
  input logic        done_res,
  input logic        last_result
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({fill_kind, start_bit, length_or_pattern, line_count, completed_bits,
               done_res, last_result}))
    else $error("stalled result word changed");

  // A word that writes nothing carries no offset and no length.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill_kind == FILL_NONE |-> start_bit == 32'd0 &&
      length_or_pattern == 26'd0)
    else $error("empty fill with nonzero offset or length");

  // Only a run close can be followed by another word of the same code.
  a_first_is_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> fill_kind == FILL_ZEROS || fill_kind == FILL_ONES)
    else $error("non-final word is not a run close");

  // The literal that follows a run close is ready in the very next cycle.
  a_literal_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid && fill_kind == FILL_LIT &&
      last_result)
    else $error("run close not followed by its literal");

endmodule

bind sixbit_run_length_plane_decoder rld_checker u_rld_checker (.*);
